// ===== sv/weighted_sigmoid_bce_loss_assert.svh =====
// Assertion macros for the RTL in weighted_sigmoid_bce_loss.sv.
`ifndef WEIGHTED_SIGMOID_BCE_LOSS_ASSERT_SVH
`define WEIGHTED_SIGMOID_BCE_LOSS_ASSERT_SVH
`ifndef SYNTH
`define WSBL_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define WSBL_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define WSBL_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WSBL_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== sv/wsbl_pkg.sv =====
`default_nettype none
package wsbl_pkg;

    localparam int MAX_CHANNELS_DEF = 64;
    localparam int TABLE_DEPTH_DEF  = 256;
    localparam int FRAC_BITS        = 12;
    localparam int ONE              = 1 << FRAC_BITS;

    localparam longint Q30_ONE = 64'sd1 << 30;
    localparam longint LN2_Q30 = 64'sd744261118;

    localparam logic [1:0] CFG_CHANNEL_COUNT = 2'd0;
    localparam logic [1:0] CFG_BATCH_COUNT   = 2'd1;
    localparam logic [1:0] CFG_LOSS_SCALE    = 2'd2;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_DATA = 1'b1;

    // Restoring long division on non-negative values, for table build only.
    function automatic longint udiv(input longint n, input longint d);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r << 1) | ((n >> b) & 64'sd1);
            if (r >= d) begin
                r = r - d;
                q = q | (64'sd1 << b);
            end
        end
        return q;
    endfunction

    function automatic longint exp_neg_q30(input longint a);
        longint n;
        longint r;
        longint sum;
        longint term;
        n = udiv(a, LN2_Q30);
        r = a - n * LN2_Q30;
        sum = Q30_ONE;
        term = Q30_ONE;
        for (int k = 1; k <= 24; k++) begin
            term = udiv((term * r) >> 30, longint'(k));
            if ((k & 1) != 0) sum = sum - term;
            else sum = sum + term;
        end
        if (sum < 0) sum = 0;
        if (n >= 40) return 0;
        return sum >>> n;
    endfunction

    function automatic longint log1p_q30(input longint y);
        longint z;
        longint z2;
        longint sum;
        longint p;
        z = udiv(y << 30, 2 * Q30_ONE + y);
        z2 = (z * z) >> 30;
        sum = z;
        p = z;
        for (int k = 3; k <= 41; k += 2) begin
            p = (p * z2) >> 30;
            sum = sum + udiv(p, longint'(k));
        end
        return 2 * sum;
    endfunction

    function automatic longint bin_center(input int i, input int depth);
        return udiv(longint'(2 * i + 1) << (44 - FRAC_BITS), longint'(depth));
    endfunction

    function automatic logic [15:0] sp_entry(input int i, input int depth);
        longint y;
        longint v;
        y = exp_neg_q30(bin_center(i, depth));
        v = log1p_q30(y);
        return 16'((v + (64'sd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    endfunction

    function automatic logic [15:0] sig_entry(input int i, input int depth);
        longint y;
        longint v;
        y = exp_neg_q30(bin_center(i, depth));
        v = udiv(64'sd1 << 60, Q30_ONE + y);
        return 16'((v + (64'sd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    endfunction

endpackage
`default_nettype wire

// ===== sv/wsbl_ram.sv =====
`default_nettype none
module wsbl_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== sv/weighted_sigmoid_bce_loss.sv =====
// Channel   Dir  Payload
// s_        in   tdata: logit, target, weight_index, weight_value; tuser: operation;
//                tlast: last of batch
// m_        out  tdata: gradient, loss; tuser: loss_valid
// cfg_      in   plain write: channel_count, batch_count, loss_scale
//
// A weight load is taken in ST_IDLE and the block stays idle. A data beat
// runs the 47-step shared restoring divider once for the gradient and, on
// the last beat of a batch, once more for the batch loss.
// Weights sit in a 1R1W RAM; per-entry valid bits cleared by reset make an
// unwritten entry read as 1.0, so no clearing pass is needed.
// Reset is synchronous, active low. A waiting result is held in the output
// register while the next item is already taken and worked on.
`default_nettype none
`include "weighted_sigmoid_bce_loss_assert.svh"
module weighted_sigmoid_bce_loss import wsbl_pkg::*; #(
    parameter int MAX_CHANNELS = MAX_CHANNELS_DEF,
    parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [15:0] logit, [28:16] target, [34:29] weight_index, [50:35] weight_value
    input  wire logic [55:0] s_tdata,
    // [0] operation
    input  wire logic [0:0]  s_tuser,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [15:0] gradient, [46:16] loss, [47] zero
    output logic [47:0]      m_tdata,
    // [0] loss_valid
    output logic [0:0]       m_tuser,
    input  wire logic        cfg_wr_en,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_data
);
    localparam int AW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int TW = $clog2(TABLE_DEPTH);
    localparam int DW = 47;
    localparam int CNTW = $clog2(DW);

    typedef enum logic [3:0] {
        ST_IDLE, ST_LOOK, ST_MUL1, ST_MUL2, ST_MUL3, ST_ACC,
        ST_DIVG, ST_GRAD, ST_DIVL, ST_LOSS, ST_OUT
    } state_t;

    typedef logic [15:0] rom_t [TABLE_DEPTH];

    function automatic rom_t build_rom(input bit want_sig);
        rom_t r;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            r[i] = want_sig ? sig_entry(i, TABLE_DEPTH) : sp_entry(i, TABLE_DEPTH);
        end
        return r;
    endfunction

    localparam rom_t SP_ROM  = build_rom(1'b0);
    localparam rom_t SIG_ROM = build_rom(1'b1);

    // Input fields
    logic signed [15:0] in_logit;
    logic        [12:0] in_target;
    logic        [5:0]  in_widx;
    logic        [15:0] in_wval;
    assign in_logit  = s_tdata[15:0];
    assign in_target = s_tdata[28:16];
    assign in_widx   = s_tdata[34:29];
    assign in_wval   = s_tdata[50:35];

    // Configuration
    logic        [6:0]  cc_cfg_reg;
    logic        [15:0] bc_cfg_reg;
    logic signed [15:0] ls_cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cc_cfg_reg <= 7'd1;
            bc_cfg_reg <= 16'd1;
            ls_cfg_reg <= 16'(ONE);
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_CHANNEL_COUNT: cc_cfg_reg <= cfg_data[6:0];
                CFG_BATCH_COUNT:   bc_cfg_reg <= cfg_data;
                CFG_LOSS_SCALE:    ls_cfg_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp channel count into 1..MAX_CHANNELS; zero batch count acts as one.
    logic [10:0] cc_eff;
    logic [15:0] bc_eff;
    always_comb begin
        if (cc_cfg_reg == 7'd0) cc_eff = 11'd1;
        else if (11'(cc_cfg_reg) > 11'(MAX_CHANNELS)) cc_eff = 11'(MAX_CHANNELS);
        else cc_eff = 11'(cc_cfg_reg);
    end
    assign bc_eff = (bc_cfg_reg == 16'd0) ? 16'd1 : bc_cfg_reg;

    // Weight position
    logic [AW-1:0] pos_reg;
    logic [AW-1:0] wi;
    logic [AW-1:0] pos_next;
    assign wi = (11'(pos_reg) < cc_eff) ? pos_reg : '0;
    assign pos_next = (11'(wi) + 11'd1 >= cc_eff) ? '0 : AW'(11'(wi) + 11'd1);

    // Load address
    logic [15:0]   widx_ext;
    logic          load_ok;
    logic [AW-1:0] load_addr;
    assign widx_ext  = 16'(in_widx);
    assign load_ok   = widx_ext < 16'(MAX_CHANNELS);
    assign load_addr = widx_ext[AW-1:0];

    logic       in_fire;
    logic       load_fire;
    logic       data_fire;
    state_t     state_reg;
    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign load_fire = in_fire && (s_tuser[0] == OP_LOAD);
    assign data_fire = in_fire && (s_tuser[0] == OP_DATA);

    logic [15:0] ram_rdata;
    wsbl_ram #(
        .WIDTH(16),
        .DEPTH(MAX_CHANNELS)
    ) u_wram (
        .aclk    (aclk),
        .wr_en   (load_fire && load_ok),
        .wr_addr (load_addr),
        .wr_data (in_wval),
        .rd_addr (wi),
        .rd_data (ram_rdata)
    );

    // Per-entry written flags
    logic [MAX_CHANNELS-1:0] wvalid_reg;

    // Datapath registers
    logic signed [15:0] x_reg;
    logic        [12:0] t_reg;
    logic               last_reg;
    logic [AW-1:0]      wi_reg;
    logic        [15:0] w_reg;
    logic        [15:0] sp_reg;
    logic        [15:0] sig_reg;
    logic signed [30:0] lin_reg;
    logic signed [14:0] ds_reg;
    logic signed [19:0] elem_reg;
    logic signed [31:0] wd_reg;
    logic signed [36:0] we_reg;
    logic signed [47:0] num_reg;
    logic signed [47:0] acc_reg;
    logic               gneg_reg;
    logic        [15:0] rem_reg;
    logic [DW-1:0]      quo_reg;
    logic [CNTW-1:0]    cnt_reg;
    logic        [15:0] grad_reg;
    logic        [30:0] loss_reg;

    logic               m_valid_reg;
    logic        [15:0] m_grad_reg;
    logic        [30:0] m_loss_reg;
    logic               m_lv_reg;

    // Table lookup from |x|
    logic        x_neg;
    logic [15:0] ax;
    logic [15:0] ax_sh;
    logic [TW-1:0] tidx;
    assign x_neg = x_reg[15];
    assign ax    = x_neg ? 16'(-x_reg) : 16'(x_reg);
    assign ax_sh = ax >> (15 - TW);
    assign tidx  = (ax_sh >= 16'(TABLE_DEPTH)) ? TW'(TABLE_DEPTH - 1) : ax_sh[TW-1:0];

    // Linear term and sigmoid minus target
    logic signed [13:0] one_mt;
    logic        [29:0] lin_neg;
    logic signed [29:0] lin_pos;
    logic signed [13:0] s_val;
    assign one_mt  = 14'(ONE) - $signed({1'b0, t_reg});
    assign lin_neg = 30'(ax) * 30'(t_reg);
    assign lin_pos = x_reg * one_mt;
    assign s_val   = x_neg ? (14'(ONE) - $signed({1'b0, sig_reg[12:0]}))
                           : $signed({1'b0, sig_reg[12:0]});

    // Rounded linear term
    logic [30:0] lin_mag;
    logic [18:0] lin_rnd;
    logic signed [19:0] elem_val;
    assign lin_mag  = lin_reg[30] ? 31'(-lin_reg) : 31'(lin_reg);
    assign lin_rnd  = 19'((lin_mag + 31'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    assign elem_val = $signed({4'd0, sp_reg})
                    + (lin_reg[30] ? -$signed({1'b0, lin_rnd}) : $signed({1'b0, lin_rnd}));

    // Accumulate rounded weighted loss with saturation
    logic [36:0] we_mag;
    logic [24:0] we_rnd;
    logic signed [48:0] acc_sum;
    logic signed [47:0] acc_sat;
    assign we_mag  = we_reg[36] ? 37'(-we_reg) : 37'(we_reg);
    assign we_rnd  = 25'((we_mag + 37'(1 << (FRAC_BITS - 1))) >> FRAC_BITS);
    assign acc_sum = 49'(acc_reg)
                   + (we_reg[36] ? -$signed({24'd0, we_rnd}) : $signed({24'd0, we_rnd}));
    always_comb begin
        if (acc_sum > 49'sh0_7FFF_FFFF_FFFF) acc_sat = 48'sh7FFF_FFFF_FFFF;
        else if (acc_sum < -49'sh0_8000_0000_0000) acc_sat = -48'sh8000_0000_0000;
        else acc_sat = 48'(acc_sum);
    end

    // One restoring divider step
    logic [16:0] div_sh;
    logic        div_ge;
    assign div_sh = {rem_reg, quo_reg[DW-1]};
    assign div_ge = div_sh >= {1'b0, bc_eff};

    // Gradient rounding and saturation
    logic [23:0] gmag;
    logic [15:0] grad_val;
    assign gmag = 24'((48'(quo_reg) + 48'(1 << (2 * FRAC_BITS - 1))) >> (2 * FRAC_BITS));
    always_comb begin
        if (gneg_reg) grad_val = (gmag > 24'd32768) ? 16'h8000 : 16'(-gmag);
        else grad_val = (gmag > 24'd32767) ? 16'h7FFF : gmag[15:0];
    end

    logic [DW-1:0] num_mag;
    assign num_mag = num_reg[47] ? DW'(-num_reg) : DW'(num_reg);

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            acc_reg     <= '0;
            wvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (load_fire && load_ok) begin
                        wvalid_reg[load_addr] <= 1'b1;
                    end
                    if (data_fire) begin
                        x_reg     <= in_logit;
                        t_reg     <= in_target;
                        last_reg  <= s_tlast;
                        wi_reg    <= wi;
                        pos_reg   <= s_tlast ? '0 : pos_next;
                        state_reg <= ST_LOOK;
                    end
                end
                ST_LOOK: begin
                    w_reg     <= wvalid_reg[wi_reg] ? ram_rdata : 16'(ONE);
                    sp_reg    <= SP_ROM[tidx];
                    sig_reg   <= SIG_ROM[tidx];
                    state_reg <= ST_MUL1;
                end
                ST_MUL1: begin
                    lin_reg   <= x_neg ? $signed({1'b0, lin_neg}) : 31'(lin_pos);
                    ds_reg    <= 15'(s_val) - $signed({2'b0, t_reg});
                    state_reg <= ST_MUL2;
                end
                ST_MUL2: begin
                    elem_reg  <= elem_val;
                    wd_reg    <= 32'($signed({1'b0, w_reg}) * ds_reg);
                    state_reg <= ST_MUL3;
                end
                ST_MUL3: begin
                    we_reg    <= 37'($signed({1'b0, w_reg}) * elem_reg);
                    num_reg   <= 48'(wd_reg * ls_cfg_reg);
                    state_reg <= ST_ACC;
                end
                ST_ACC: begin
                    acc_reg   <= acc_sat;
                    gneg_reg  <= num_reg[47];
                    rem_reg   <= '0;
                    quo_reg   <= num_mag;
                    cnt_reg   <= CNTW'(DW - 1);
                    state_reg <= ST_DIVG;
                end
                ST_DIVG, ST_DIVL: begin
                    rem_reg <= div_ge ? 16'(div_sh - {1'b0, bc_eff}) : div_sh[15:0];
                    quo_reg <= {quo_reg[DW-2:0], div_ge};
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0) begin
                        state_reg <= (state_reg == ST_DIVG) ? ST_GRAD : ST_LOSS;
                    end
                end
                ST_GRAD: begin
                    grad_reg <= grad_val;
                    if (last_reg) begin
                        // Negative batch loss clamps to zero.
                        rem_reg   <= '0;
                        quo_reg   <= acc_reg[47] ? '0 : acc_reg[DW-1:0];
                        cnt_reg   <= CNTW'(DW - 1);
                        state_reg <= ST_DIVL;
                    end else begin
                        loss_reg  <= '0;
                        state_reg <= ST_OUT;
                    end
                end
                ST_LOSS: begin
                    loss_reg  <= (quo_reg > DW'(31'h7FFF_FFFF)) ? 31'h7FFF_FFFF
                                                               : quo_reg[30:0];
                    acc_reg   <= '0;
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    // Hold until the output register is free.
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        m_grad_reg  <= grad_reg;
                        m_loss_reg  <= loss_reg;
                        m_lv_reg    <= last_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_loss_reg, m_grad_reg};
    assign m_tuser  = m_lv_reg;

    `WSBL_ASSERT_IMP(a_no_accept_busy, aclk, aresetn, state_reg == ST_DIVG || state_reg == ST_DIVL, !s_tready)
    `WSBL_ASSERT_NXT(a_data_starts, aclk, aresetn, data_fire, state_reg == ST_LOOK)
    `WSBL_ASSERT_IMP(a_loss_only_last, aclk, aresetn, m_tvalid && !m_tuser[0], m_tdata[46:16] == 31'd0)
    `WSBL_ASSERT_NXT(a_load_stays_idle, aclk, aresetn, load_fire, state_reg == ST_IDLE)

endmodule
`default_nettype wire
